// ===== design/ckt_pkg.sv =====
package ckt_pkg;

  localparam int KEYWORD_SLOTS = 7;
  localparam int KEYWORD_BYTES = 8;
  localparam int KEY_W         = 8 * KEYWORD_BYTES;
  localparam int SLOT_W        = $clog2(KEYWORD_SLOTS);
  localparam int POS_W         = $clog2(KEYWORD_BYTES);
  localparam int WLEN_W        = $clog2(KEYWORD_BYTES + 2);
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 6;
  localparam int REG_IDX_W     = 3;
  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

  localparam logic [REG_IDX_W-1:0] REG_KEYWORD_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEYWORD_0     = 3'd1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic KIND_PARAM   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_WORD   = 6'b000010,
    PH_GAP    = 6'b000100,
    PH_PARAM  = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_REJECT = 6'b100000
  } phase_t;

  typedef logic [KEYWORD_SLOTS-1:0][KEY_W-1:0] keywords_t;

  typedef struct packed {
    logic              result_kind;
    logic [7:0]        param_char;
    logic              accepted;
    logic [SLOT_W-1:0] command_index;
    logic              run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_stop(logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SEMI);
  endfunction

endpackage

// ===== design/ckt_scan.sv =====
module ckt_scan
  import ckt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire_i,
  input  logic              has_char_i,
  input  logic [7:0]        line_char_i,
  input  logic              end_of_line_i,
  input  logic [2:0]        keyword_count_i,
  input  keywords_t         keywords_i,
  output push_t             push_o
);

  phase_t              phase_r, phase_nxt;
  logic [WLEN_W-1:0]   wlen_r, wlen_nxt;
  logic [KEYWORD_SLOTS-1:0] mask_r, mask_nxt;
  logic [SLOT_W-1:0]   fidx_r, fidx_nxt;

  function automatic logic [SLOT_W:0] find_key(logic [KEYWORD_SLOTS-1:0] mm,
                                               logic [WLEN_W-1:0] wl,
                                               keywords_t kw,
                                               logic [2:0] cnt);
    logic              hit;
    logic [SLOT_W-1:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int k = 0; k < KEYWORD_SLOTS; k++) begin
      if (!hit && k < int'(cnt) && mm[k] && int'(wl) <= KEYWORD_BYTES &&
          (int'(wl) == KEYWORD_BYTES || kw[k][8*wl[POS_W-1:0] +: 8] == CH_NUL)) begin
        hit = 1'b1;
        idx = SLOT_W'(k);
      end
    end
    return {hit, idx};
  endfunction

  always_comb begin
    phase_t                   ph;
    logic [WLEN_W-1:0]        wl;
    logic [KEYWORD_SLOTS-1:0] mm;
    logic [SLOT_W-1:0]        fi;
    logic [SLOT_W:0]          fk;
    logic                     emit;
    logic                     acc;
    result_t                  pr;
    result_t                  vr;
    ph   = phase_r;
    wl   = wlen_r;
    mm   = mask_r;
    fi   = fidx_r;
    fk   = '0;
    emit = 1'b0;
    acc  = 1'b0;

    if (has_char_i) begin
      if (ph == PH_LEAD) begin
        if (is_stop(line_char_i)) begin
          ph = PH_REJECT;
        end else if (!is_space(line_char_i)) begin
          ph = PH_WORD;
        end
      end
      if (ph == PH_WORD) begin
        if (is_letter(line_char_i)) begin
          if (int'(wl) >= KEYWORD_BYTES) begin
            mm = '0;
            wl = WLEN_W'(KEYWORD_BYTES + 1);
          end else begin
            for (int k = 0; k < KEYWORD_SLOTS; k++) begin
              if (keywords_i[k][8*wl[POS_W-1:0] +: 8] != line_char_i) begin
                mm[k] = 1'b0;
              end
            end
            wl = wl + 1'b1;
          end
        end else begin
          fk = find_key(mm, wl, keywords_i, keyword_count_i);
          fi = fk[SLOT_W-1:0];
          ph = fk[SLOT_W] ? PH_GAP : PH_REJECT;
        end
      end
      if (ph == PH_GAP && !is_space(line_char_i)) begin
        ph = is_stop(line_char_i) ? PH_DONE : PH_PARAM;
      end
      if (ph == PH_PARAM) begin
        emit = 1'b1;
      end
    end

    if (ph == PH_WORD) begin
      fk  = find_key(mm, wl, keywords_i, keyword_count_i);
      acc = fk[SLOT_W];
      if (fk[SLOT_W]) begin
        fi = fk[SLOT_W-1:0];
      end
    end else begin
      acc = (ph == PH_GAP) || (ph == PH_PARAM) || (ph == PH_DONE);
    end

    pr.result_kind   = KIND_PARAM;
    pr.param_char    = line_char_i;
    pr.accepted      = 1'b0;
    pr.command_index = '0;
    pr.run_last      = 1'b0;

    vr.result_kind   = KIND_VERDICT;
    vr.param_char    = CH_NUL;
    vr.accepted      = acc;
    vr.command_index = acc ? fi : '0;
    vr.run_last      = 1'b1;

    push_o.count  = 2'(emit) + 2'(end_of_line_i);
    push_o.first  = emit ? pr : vr;
    push_o.second = vr;
    if (!fire_i) begin
      push_o.count = 2'd0;
    end

    if (end_of_line_i) begin
      phase_nxt = PH_LEAD;
      wlen_nxt  = '0;
      mask_nxt  = '1;
      fidx_nxt  = '0;
    end else begin
      phase_nxt = ph;
      wlen_nxt  = wl;
      mask_nxt  = mm;
      fidx_nxt  = fi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      wlen_r  <= '0;
      mask_r  <= '1;
      fidx_r  <= '0;
    end else if (fire_i) begin
      phase_r <= phase_nxt;
      wlen_r  <= wlen_nxt;
      mask_r  <= mask_nxt;
      fidx_r  <= fidx_nxt;
    end
  end

endmodule

// ===== design/ckt_outq.sv =====
module ckt_outq
  import ckt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    valid_o,
  output logic    full_o
);

  result_t [OUTQ_DEPTH-1:0] q_r, q_nxt;
  logic [OUTQ_CNT_W-1:0]    count_r, count_nxt;

  always_comb begin
    result_t [OUTQ_DEPTH-1:0] sh;
    logic [OUTQ_CNT_W-1:0]    base;
    sh   = q_r >> $bits(result_t);
    base = count_r - OUTQ_CNT_W'(pop_i);
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      q_nxt[i] = pop_i ? sh[i] : q_r[i];
      if (push_i.count != 2'd0 && i == int'(base)) begin
        q_nxt[i] = push_i.first;
      end
      if (push_i.count == 2'd2 && i == int'(base) + 1) begin
        q_nxt[i] = push_i.second;
      end
    end
    count_nxt = base + OUTQ_CNT_W'(push_i.count);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_o  = q_r[0];
  assign valid_o = (count_r != '0);
  assign full_o  = (count_r > OUTQ_CNT_W'(OUTQ_DEPTH - 2));

endmodule

// ===== design/command_keyword_tokenizer.sv =====
// Channel  Handshake            Payload
// in       in_valid/in_stall    in_has_char, in_line_char, in_end_of_line
// out      out_valid/out_stall  out_result_kind, out_param_char, out_accepted,
//                               out_command_index, out_run_last
// cfg      psel/penable/pready  paddr, pwdata, prdata (64-bit registers at 8*i)
//
// Each input beat is scanned in the cycle it is accepted, one beat per cycle.
// A beat yields up to two result beats into a four-entry output queue.
// The input stalls while fewer than two queue entries are free.
// Results leave at one beat per cycle when out_stall is low, so two-result beats lower the input rate.
// Reset clears the scan state, empties the queue and clears all registers.
module command_keyword_tokenizer
  import ckt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_has_char,
  input  logic [7:0]            in_line_char,
  input  logic                  in_end_of_line,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [7:0]            out_param_char,
  output logic                  out_accepted,
  output logic [SLOT_W-1:0]     out_command_index,
  output logic                  out_run_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [2:0]           kw_count_r;
  keywords_t            kw_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [SLOT_W-1:0]    kw_sel;
  logic                 cfg_wr;
  logic                 fire;
  logic                 full;
  push_t                push;
  result_t              head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign kw_sel  = SLOT_W'(reg_idx - REG_KEYWORD_0);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_count_r <= '0;
      kw_r       <= '0;
    end else if (cfg_wr) begin
      if (reg_idx == REG_KEYWORD_COUNT) begin
        kw_count_r <= pwdata[2:0];
      end else begin
        kw_r[kw_sel] <= pwdata;
      end
    end
  end

  always_comb begin
    if (reg_idx == REG_KEYWORD_COUNT) begin
      prdata = CFG_DATA_W'(kw_count_r);
    end else begin
      prdata = kw_r[kw_sel];
    end
  end

  assign in_stall = full;
  assign fire     = in_valid && !full;

  ckt_scan u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire_i          (fire),
    .has_char_i      (in_has_char),
    .line_char_i     (in_line_char),
    .end_of_line_i   (in_end_of_line),
    .keyword_count_i (kw_count_r),
    .keywords_i      (kw_r),
    .push_o          (push)
  );

  ckt_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .pop_i   (out_valid && !out_stall),
    .head_o  (head),
    .valid_o (out_valid),
    .full_o  (full)
  );

  assign out_result_kind   = head.result_kind;
  assign out_param_char    = head.param_char;
  assign out_accepted      = head.accepted;
  assign out_command_index = head.command_index;
  assign out_run_last      = head.run_last;

endmodule

// ===== design/ckt_checker.sv =====
module ckt_checker
  import ckt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_result_kind,
  input logic [7:0]        out_param_char,
  input logic              out_accepted,
  input logic [SLOT_W-1:0] out_command_index,
  input logic              out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_param_char) && $stable(out_accepted) &&
      $stable(out_command_index) && $stable(out_run_last))
    else $error("stalled result beat changed");

  a_param_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PARAM |->
      !out_accepted && out_command_index == '0 && !out_run_last)
    else $error("parameter beat carries verdict fields");

  a_verdict_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_VERDICT |->
      out_run_last && out_param_char == CH_NUL &&
      (out_accepted || out_command_index == '0))
    else $error("malformed verdict beat");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_command_index) < KEYWORD_SLOTS)
    else $error("command index out of range");

endmodule

bind command_keyword_tokenizer ckt_checker u_ckt_checker (.*);
